@@ sv/psq_pkg.sv @@
// Shared types, constants and control codes for the positional sequence store.
`default_nettype none

package psq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 11;
    localparam int DATA_W   = 32;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } psq_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } psq_status_t;

    typedef struct packed {
        psq_op_t            operation;
        logic [POS_W-1:0]   position;
        logic signed [DATA_W-1:0] item_value;
    } psq_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        psq_status_t        status;
        logic [POS_W-1:0]   element_count;
    } psq_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ_WAIT,
        S_SHIFT,
        S_DRAIN,
        S_WRITE,
        S_FINISH
    } psq_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic decide;
        logic shift_rd;
        logic read_issue;
        logic read_capture;
        logic write_new;
        logic out_load;
    } psq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_read;
        logic err;
        logic shift_needed;
        logic shift_last;
        logic out_free;
    } psq_stat_t;

endpackage

`default_nettype wire

@@ sv/psq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module psq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ sv/psq_ctrl.sv @@
// Control state machine: sequences checks, shifting, reads and result hand-off.
`default_nettype none

module psq_ctrl
    import psq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire psq_stat_t stat,
    output psq_cmd_t       cmd
);

    psq_state_t state_reg;
    psq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (stat.err)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.is_read)
                begin
                    cmd.read_issue = 1'b1;
                    state_next     = S_READ_WAIT;
                end
                else if (stat.shift_needed)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_READ_WAIT:
            begin
                cmd.read_capture = 1'b1;
                state_next       = S_FINISH;
            end
            S_SHIFT:
            begin
                cmd.shift_rd = 1'b1;
                if (stat.shift_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last moved element is written back this cycle
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write_new = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/psq_datapath.sv @@
// Datapath: element RAM, count, shift pointer, result and output registers.
`default_nettype none

module psq_datapath
    import psq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire psq_req_t req,
    input  wire psq_cmd_t cmd,
    output psq_stat_t     stat,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output psq_rsp_t      rsp
);

    psq_req_t                 item_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [ADDR_W-1:0]        ptr_reg;
    logic                     wr_pend_reg;
    logic [ADDR_W-1:0]        wr_addr_reg;
    psq_status_t              res_status_reg;
    logic signed [DATA_W-1:0] res_value_reg;
    logic                     rsp_valid_reg;
    psq_rsp_t                 rsp_reg;

    logic                     full;
    logic                     range_err;
    logic [POS_W-1:0]         pos_eff;
    logic [POS_W-1:0]         pos_m1;
    psq_status_t              code;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    always_comb
    begin
        full    = (item_reg.operation == OP_INSERT) && (count_reg >= CNT_W'(CAPACITY));
        // an insert into an empty store ignores the position
        pos_eff = (count_reg == '0) ? '0 : item_reg.position;
        pos_m1  = item_reg.position - POS_W'(1);
        if (item_reg.operation == OP_READ)
        begin
            range_err = (item_reg.position == '0)
                     || (item_reg.position > POS_W'(count_reg));
        end
        else
        begin
            range_err = (count_reg != '0) && (item_reg.position > POS_W'(count_reg));
        end
        if (full)
        begin
            code = ST_FULL;
        end
        else if (range_err)
        begin
            code = ST_RANGE;
        end
        else
        begin
            code = ST_OK;
        end
        stat.is_read      = (item_reg.operation == OP_READ);
        stat.err          = (code != ST_OK);
        stat.shift_needed = (POS_W'(count_reg) > pos_eff);
        stat.shift_last   = (ptr_reg == pos_eff[ADDR_W-1:0]);
        stat.out_free     = !rsp_valid_reg || !rsp_stall;
    end

    // moved element goes up one slot; otherwise the new value lands
    always_comb
    begin
        if (wr_pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_reg;
            ram_wdata = ram_rdata;
        end
        else
        begin
            ram_we    = cmd.write_new;
            ram_waddr = pos_eff[ADDR_W-1:0];
            ram_wdata = item_reg.item_value;
        end
        ram_raddr = cmd.shift_rd ? ptr_reg : pos_m1[ADDR_W-1:0];
    end

    psq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
        if (cmd.decide)
        begin
            res_status_reg <= code;
            res_value_reg  <= '0;
            ptr_reg        <= ADDR_W'(count_reg - CNT_W'(1));
        end
        if (cmd.shift_rd)
        begin
            ptr_reg     <= ptr_reg - ADDR_W'(1);
            wr_addr_reg <= ptr_reg + ADDR_W'(1);
        end
        if (cmd.read_capture)
        begin
            res_value_reg <= ram_rdata;
        end
        if (cmd.out_load)
        begin
            rsp_reg.read_value    <= res_value_reg;
            rsp_reg.status        <= res_status_reg;
            rsp_reg.element_count <= POS_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= cmd.shift_rd;
            if (cmd.write_new)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("element count moved by other than one");

    a_wr_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> $past(cmd.shift_rd))
        else $error("shift write without a preceding shift read");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_new && wr_pend_reg))
        else $error("new value and shifted element collide on write port");

    a_capture_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_capture |-> $past(cmd.read_issue))
        else $error("read data captured without a read issued");

endmodule

`default_nettype wire

@@ sv/positional_sequence_store.sv @@
// Top level of the positional sequence store.
`default_nettype none

// Ordered store of up to CAPACITY signed 32-bit values kept in one RAM in
// sequence order. One item is processed at a time; req_stall is low only
// while the block is idle, and a finished result waits in an output register
// so the next item can be taken while it is pending. A read passes through
// accept, decide with the RAM read, capture and hand-off to the result
// register. An insert that moves elements passes through accept, decide, the
// shift, a drain of the last move, the write and the hand-off: the elements
// after the insertion point move up one slot each cycle through the single
// RAM read port and write port, and the drain writes back the last move. An
// append moves nothing and skips the shift and the drain. Errors go from
// decide straight to the hand-off. The hand-off of every item waits while the
// previous result is still stalled.
// No clearing pass is needed after reset.
module positional_sequence_store
    import psq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire psq_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output psq_rsp_t      rsp
);

    psq_cmd_t  cmd;
    psq_stat_t stat;

    psq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    psq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ tb/psq_sequence_checker.sv @@
// Checker for the positional sequence store: tracks the sequence and compares every result.
module psq_sequence_checker
    import psq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  psq_req_t    req,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  psq_rsp_t    rsp,
    output int unsigned mismatches,
    output int unsigned pending,
    output int unsigned level
);

    logic signed [DATA_W-1:0] seq_mem [CAPACITY];
    int unsigned              held;
    psq_rsp_t                 due_results [$];

    initial begin
        held       = 0;
        mismatches = 0;
        pending    = 0;
        level      = 0;
    end

    // Applies one item to the tracked sequence and returns the result it should give.
    function automatic psq_rsp_t apply_to_sequence(input psq_req_t item);
        psq_rsp_t    res;
        int unsigned at;
        res.read_value = '0;
        res.status     = ST_OK;
        at             = item.position;
        if (item.operation == OP_INSERT) begin
            // full is checked ahead of the position
            if (held >= CAPACITY) begin
                res.status = ST_FULL;
            end
            else begin
                if (held == 0)
                    at = 0;
                if (at > held) begin
                    res.status = ST_RANGE;
                end
                else begin
                    for (int i = held; i > at; i--)
                        seq_mem[i] = seq_mem[i-1];
                    seq_mem[at] = item.item_value;
                    held++;
                end
            end
        end
        else if (at == 0 || at > held) begin
            res.status = ST_RANGE;
        end
        else begin
            res.read_value = seq_mem[at-1];
        end
        res.element_count = POS_W'(held);
        return res;
    endfunction

    always @(posedge clk) begin
        psq_rsp_t want;
        if (rst_n) begin
            if (rsp_valid && !rsp_stall) begin
                if (due_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    $display("%0t: unexpected result: expected none, %s %0d status %0d count %0d",
                             $time, "got value", rsp.read_value, rsp.status,
                             rsp.element_count);
                end
                else begin
                    want = due_results.pop_front();
                    if (rsp.read_value !== want.read_value || rsp.status !== want.status ||
                        rsp.element_count !== want.element_count) begin
                        mismatches <= mismatches + 1;
                        $display("%0t: result mismatch: expected value %0d status %0d count %0d,",
                                 $time, want.read_value, want.status, want.element_count);
                        $display("    got value %0d status %0d count %0d",
                                 rsp.read_value, rsp.status, rsp.element_count);
                    end
                end
            end
            if (req_valid && !req_stall)
                due_results.push_back(apply_to_sequence(req));
            pending <= due_results.size();
            level   <= held;
        end
    end

endmodule

@@ tb/positional_sequence_store_test.sv @@
// Testbench top for the positional sequence store: clock, reset, stimulus and verdict.
module positional_sequence_store_test;
    import psq_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    localparam int unsigned PHASE_ITEMS  = 445;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned POS_MAX      = 2047;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    psq_req_t    req       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    psq_rsp_t    rsp;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned level;

    int unsigned send_gap_pct = 11;
    int unsigned recv_gap_pct = 72;
    int unsigned hold_ticket  = 0;
    int unsigned cycles;

    positional_sequence_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    psq_sequence_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending),
        .level      (level)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random stall, or a long hold-off when the ticket moves.
    initial begin
        int unsigned hold_left;
        int unsigned seen_ticket;
        hold_left   = 0;
        seen_ticket = 0;
        forever begin
            @(posedge clk);
            if (hold_ticket != seen_ticket) begin
                seen_ticket = hold_ticket;
                hold_left   = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else begin
                rsp_stall <= ($urandom_range(99) < recv_gap_pct);
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("positional_sequence_store_test: FAIL");
        $finish;
    end

    function automatic psq_req_t make_req(input psq_op_t op, input int unsigned pos,
                                          input logic [DATA_W-1:0] value);
        psq_req_t r;
        r.operation  = op;
        r.position   = POS_W'(pos);
        r.item_value = value;
        return r;
    endfunction

    // Mostly inserts until the store fills, then mostly reads; n is the current count.
    function automatic psq_req_t random_item(input int unsigned n);
        psq_req_t    r;
        int unsigned pick;
        r.item_value = $urandom();
        pick = $urandom_range(99);
        if ((n < CAPACITY) ? (pick < 92) : (pick < 45)) begin
            r.operation = OP_INSERT;
            pick = $urandom_range(99);
            if (pick < 5)
                r.position = POS_W'($urandom_range(POS_MAX, n + 1));
            else if (pick < 30)
                r.position = POS_W'(n);
            else if (pick < 45)
                r.position = '0;
            else
                r.position = POS_W'($urandom_range(n, 0));
        end
        else begin
            r.operation = OP_READ;
            pick = $urandom_range(99);
            if (pick < 4)
                r.position = '0;
            else if (pick < 10 || n == 0)
                r.position = POS_W'($urandom_range(POS_MAX, n + 1));
            else if (pick < 30)
                r.position = POS_W'(1);
            else if (pick < 50)
                r.position = POS_W'(n);
            else
                r.position = POS_W'($urandom_range(n, 1));
        end
        return r;
    endfunction

    task automatic offer(input psq_req_t item);
        if ($urandom_range(99) < send_gap_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_gap_pct)
                @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, then a small hand-built sequence
        offer(make_req(OP_READ,   1,       32'h0000_0000));
        offer(make_req(OP_READ,   0,       32'h0000_0000));
        offer(make_req(OP_READ,   POS_MAX, 32'hFFFF_FFFF));
        offer(make_req(OP_INSERT, POS_MAX, 32'h7FFF_FFFF));    // position ignored when empty
        offer(make_req(OP_INSERT, 2,       32'h1234_5678));    // past the append position, so out of range
        offer(make_req(OP_INSERT, 0,       32'h8000_0000));
        offer(make_req(OP_INSERT, 2,       32'hFFFF_FFFF));
        offer(make_req(OP_INSERT, 1,       32'h0000_0000));
        offer(make_req(OP_INSERT, POS_MAX, 32'hAAAA_AAAA));
        offer(make_req(OP_INSERT, 1024,    32'h5555_5555));
        offer(make_req(OP_READ,   0,       32'h0000_0000));
        offer(make_req(OP_READ,   1,       32'h0000_0000));
        offer(make_req(OP_READ,   4,       32'h0000_0000));
        offer(make_req(OP_READ,   5,       32'h0000_0000));
        offer(make_req(OP_READ,   POS_MAX, 32'h0000_0000));
        offer(make_req(OP_READ,   2,       32'hDEAD_BEEF));    // value is ignored on reads
        offer(make_req(OP_INSERT, 4,       32'h5555_5555));
        offer(make_req(OP_INSERT, 3,       32'hAAAA_AAAA));
        offer(make_req(OP_READ,   3,       32'h0000_0000));
        offer(make_req(OP_READ,   6,       32'h0000_0000));

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct = 11;
                    recv_gap_pct <= 72;
                end
                1: begin
                    send_gap_pct = 72;
                    recv_gap_pct <= 11;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_gap_pct <= 0;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == 100)
                    hold_ticket <= hold_ticket + 1;
                if (k == 300)
                    wait_drained();
                offer(random_item(level));
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("positional_sequence_store_test: PASS");
        else
            $display("positional_sequence_store_test: FAIL");
        $finish;
    end

endmodule
